@@ design/arm_dp_pkg.sv @@
// ----------------------------------------------------------------------------
// ARM data-processing ALU package
// Beat types, instruction field codes and flag bit positions shared by the
// shifter, the ALU and the top level.
// ----------------------------------------------------------------------------
package arm_dp_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned FlagsW = 4;

    // Flag positions within the NZCV nibble.
    localparam int unsigned FlagN = 3;
    localparam int unsigned FlagZ = 2;
    localparam int unsigned FlagC = 1;
    localparam int unsigned FlagV = 0;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } t_alu_op;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
        COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
        COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
        COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
    } t_cond;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } t_shift_kind;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [7:0]  rs_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic [3:0]  rd_index;
        logic        write_rd;
        logic        cond_passed;
        logic [3:0]  flags_nzcv;
    } t_out_item;

    // Operand 2 and the carry out of the barrel shifter.
    typedef struct packed {
        logic [DataW-1:0] op2;
        logic             carry;
    } t_shift_out;

endpackage

@@ design/arm_dp_shifter.sv @@
// ----------------------------------------------------------------------------
// ARM data-processing barrel shifter
// Forms operand 2 and the shifter carry from the rotated immediate, or from
// Rm shifted by an immediate amount or by the low byte of Rs.
// ----------------------------------------------------------------------------
module arm_dp_shifter (
    input  logic [31:0]             i_instr,
    input  logic [31:0]             i_rm_value,
    input  logic [7:0]              i_rs_value,
    input  logic                    i_carry,
    output arm_dp_pkg::t_shift_out  o_shift
);
    import arm_dp_pkg::*;

    // Returns {carry, value}.
    function automatic logic [DataW:0] shift_by(
        input logic [DataW-1:0] val,
        input logic [7:0]       amt,
        input t_shift_kind      kind,
        input logic             cin
    );
        logic [DataW:0]     wide;
        logic [2*DataW-1:0] twice;
        logic               sign;
        logic               big;
        logic               exact;
        logic [DataW:0]     res;
        sign  = val[DataW-1];
        big   = (amt >= 8'd32);
        exact = (amt == 8'd32);
        wide  = '0;
        twice = '0;
        if (amt == 8'd0) begin
            res = {cin, val};
        end else begin
            case (kind)
                SHIFT_LSL: begin
                    wide = {1'b0, val} << amt[4:0];
                    if (!big)       res = wide;
                    else if (exact) res = {val[0], {DataW{1'b0}}};
                    else            res = '0;
                end
                SHIFT_LSR: begin
                    wide = {val, 1'b0} >> amt[4:0];
                    if (!big)       res = {wide[0], wide[DataW:1]};
                    else if (exact) res = {sign, {DataW{1'b0}}};
                    else            res = '0;
                end
                SHIFT_ASR: begin
                    wide = $unsigned($signed({val, 1'b0}) >>> amt[4:0]);
                    if (!big) res = {wide[0], wide[DataW:1]};
                    else      res = {sign, {DataW{sign}}};
                end
                SHIFT_ROR: begin
                    twice = {val, val} >> amt[4:0];
                    // A whole number of turns leaves Rm as it is.
                    res = {twice[DataW-1], twice[DataW-1:0]};
                end
                default: res = {cin, val};
            endcase
        end
        return res;
    endfunction

    t_shift_kind        kind;
    logic [4:0]         imm5;
    logic [4:0]         rot;
    logic [2*DataW-1:0] imm_twice;
    logic [7:0]         amt;
    logic [DataW:0]     reg_res;

    always_comb begin
        kind      = t_shift_kind'(i_instr[6:5]);
        imm5      = i_instr[11:7];
        rot       = {i_instr[11:8], 1'b0};
        imm_twice = {24'd0, i_instr[7:0], 24'd0, i_instr[7:0]} >> rot;

        // LSR #0 and ASR #0 encode a shift by 32.
        if (i_instr[4]) begin
            amt = i_rs_value;
        end else if (imm5 == 5'd0 && (kind == SHIFT_LSR || kind == SHIFT_ASR)) begin
            amt = 8'd32;
        end else begin
            amt = {3'd0, imm5};
        end
        reg_res = shift_by(i_rm_value, amt, kind, i_carry);

        if (i_instr[25]) begin
            o_shift.op2   = imm_twice[DataW-1:0];
            o_shift.carry = (rot == 5'd0) ? i_carry : imm_twice[DataW-1];
        end else if (!i_instr[4] && imm5 == 5'd0 && kind == SHIFT_ROR) begin
            // Rotate right extended through the carry.
            o_shift.op2   = {i_carry, i_rm_value[DataW-1:1]};
            o_shift.carry = i_rm_value[0];
        end else begin
            o_shift.op2   = reg_res[DataW-1:0];
            o_shift.carry = reg_res[DataW];
        end
    end

endmodule

@@ design/arm_dp_alu.sv @@
// ----------------------------------------------------------------------------
// ARM data-processing ALU core
// Checks the condition, performs the operation on Rn and operand 2 and works
// out the flags that follow the instruction.
// ----------------------------------------------------------------------------
module arm_dp_alu (
    input  arm_dp_pkg::t_in_item    i_item,
    input  arm_dp_pkg::t_shift_out  i_shift,
    input  logic [3:0]              i_flags,
    output arm_dp_pkg::t_out_item   o_item
);
    import arm_dp_pkg::*;

    function automatic logic cond_ok(input t_cond cond, input logic [FlagsW-1:0] f);
        logic n, z, c, v, ok;
        n = f[FlagN];
        z = f[FlagZ];
        c = f[FlagC];
        v = f[FlagV];
        case (cond)
            COND_EQ: ok = z;
            COND_NE: ok = !z;
            COND_CS: ok = c;
            COND_CC: ok = !c;
            COND_MI: ok = n;
            COND_PL: ok = !n;
            COND_VS: ok = v;
            COND_VC: ok = !v;
            COND_HI: ok = c && !z;
            COND_LS: ok = !c || z;
            COND_GE: ok = (n == v);
            COND_LT: ok = (n != v);
            COND_GT: ok = !z && (n == v);
            COND_LE: ok = z || (n != v);
            COND_AL: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    t_alu_op          op;
    logic [DataW-1:0] rn;
    logic [DataW-1:0] op2;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             cin;
    logic             arith;
    logic [DataW:0]   sum;
    logic [DataW-1:0] res;
    logic             passed;
    logic             is_test;
    logic             set_flags;
    logic             wr;
    logic [FlagsW-1:0] nf;

    always_comb begin
        op    = t_alu_op'(i_item.instr[24:21]);
        rn    = i_item.rn_value;
        op2   = i_shift.op2;
        a     = '0;
        b     = '0;
        cin   = 1'b0;
        arith = 1'b0;
        res   = '0;
        case (op)
            OP_AND, OP_TST: res = rn & op2;
            OP_EOR, OP_TEQ: res = rn ^ op2;
            OP_SUB, OP_CMP: begin a = rn;  b = ~op2; cin = 1'b1;       arith = 1'b1; end
            OP_RSB:         begin a = op2; b = ~rn;  cin = 1'b1;       arith = 1'b1; end
            OP_ADD, OP_CMN: begin a = rn;  b = op2;  cin = 1'b0;       arith = 1'b1; end
            OP_ADC:         begin a = rn;  b = op2;  cin = i_flags[FlagC]; arith = 1'b1; end
            OP_SBC:         begin a = rn;  b = ~op2; cin = i_flags[FlagC]; arith = 1'b1; end
            OP_RSC:         begin a = op2; b = ~rn;  cin = i_flags[FlagC]; arith = 1'b1; end
            OP_ORR:         res = rn | op2;
            OP_MOV:         res = op2;
            OP_BIC:         res = rn & ~op2;
            default:        res = ~op2;
        endcase

        sum = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
        if (arith) begin
            res = sum[DataW-1:0];
        end

        passed    = cond_ok(t_cond'(i_item.instr[31:28]), i_flags);
        is_test   = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
        set_flags = is_test || i_item.instr[20];
        wr        = passed && !is_test;

        nf        = i_flags;
        if (passed && set_flags) begin
            nf[FlagN] = res[DataW-1];
            nf[FlagZ] = (res == '0);
            if (arith) begin
                // Subtraction carry reads as "no borrow" because b is inverted.
                nf[FlagC] = sum[DataW];
                nf[FlagV] = (~(a[DataW-1] ^ b[DataW-1])) & (a[DataW-1] ^ res[DataW-1]);
            end else begin
                nf[FlagC] = i_shift.carry;
            end
        end

        o_item.result_value = wr ? res : '0;
        o_item.rd_index     = i_item.instr[15:12];
        o_item.write_rd     = wr;
        o_item.cond_passed  = passed;
        o_item.flags_nzcv   = nf;
    end

endmodule

@@ design/arm_data_processing_alu.sv @@
// ----------------------------------------------------------------------------
// ARM data-processing ALU
// Executes one ARMv4 data-processing instruction per beat, with condition
// check, barrel shifter, sixteen ALU operations and held NZCV flags.
//
//   Channel   Handshake                 Payload
//   input     i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   output    o_out_valid / i_out_stall o_out_item (t_out_item)
//
// A beat is taken into an input register, worked in one pass of logic and
// then lands in the result register; one instruction per cycle while the
// output is not stalled, set by the single shifter-plus-adder pass.
// The flags are written as a beat leaves for the result register, so the
// next instruction always sees them. Reset clears the flags and both valids.
// A stall on the output holds the result and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module arm_data_processing_alu (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  arm_dp_pkg::t_in_item   i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output arm_dp_pkg::t_out_item  o_out_item
);
    import arm_dp_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic [FlagsW-1:0] r_flags;

    t_shift_out        shift;
    t_out_item         n_out_item;
    logic              out_adv;
    logic              in_adv;

    arm_dp_shifter u_shifter (
        .i_instr    (r_in_item.instr),
        .i_rm_value (r_in_item.rm_value),
        .i_rs_value (r_in_item.rs_value),
        .i_carry    (r_flags[FlagC]),
        .o_shift    (shift)
    );

    arm_dp_alu u_alu (
        .i_item  (r_in_item),
        .i_shift (shift),
        .i_flags (r_flags),
        .o_item  (n_out_item)
    );

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign in_adv      = !r_in_valid || out_adv;
    assign o_in_stall  = !in_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_flags <= n_out_item.flags_nzcv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (out_adv && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

@@ tb/tb_arm_data_processing_alu.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the ARM data-processing ALU
// Drives data-processing instructions with random operand values, predicts
// each result beat and the forwarded NZCV flags in a behavioural model, and
// compares every result beat field by field. Sender gaps and receiver stalls
// are varied in phases.
// ----------------------------------------------------------------------------
module tb_arm_data_processing_alu;

    import arm_dp_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic [3:0] model_nzcv = 4'b0000;
    t_out_item  exec_results_q [$];
    t_out_item  exp_beat;
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         out_stall_pct  = 0;

    arm_data_processing_alu u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ------------------------------------------------------------------
    // Behavioural model
    // ------------------------------------------------------------------
    function automatic logic cond_holds(t_cond cond, logic [3:0] f);
        logic n, z, c, v;
        n = f[FlagN];
        z = f[FlagZ];
        c = f[FlagC];
        v = f[FlagV];
        case (cond)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_shift_out shift_operand(logic [31:0] v, int amt, t_shift_kind kind,
                                                 logic cin);
        t_shift_out r;
        int         rot;
        rot     = amt % 32;
        r.op2   = v;
        r.carry = cin;
        if (amt != 0) begin
            case (kind)
                SHIFT_LSL: begin
                    if (amt < 32) begin
                        r.op2   = v << amt;
                        r.carry = v[32 - amt];
                    end else begin
                        r.op2   = '0;
                        r.carry = (amt == 32) ? v[0] : 1'b0;
                    end
                end
                SHIFT_LSR: begin
                    if (amt < 32) begin
                        r.op2   = v >> amt;
                        r.carry = v[amt - 1];
                    end else begin
                        r.op2   = '0;
                        r.carry = (amt == 32) ? v[31] : 1'b0;
                    end
                end
                SHIFT_ASR: begin
                    if (amt < 32) begin
                        r.op2   = $unsigned($signed(v) >>> amt);
                        r.carry = v[amt - 1];
                    end else begin
                        r.op2   = {32{v[31]}};
                        r.carry = v[31];
                    end
                end
                default: begin
                    // A nonzero multiple of 32 leaves the value whole.
                    if (rot == 0) begin
                        r.carry = v[31];
                    end else begin
                        r.op2   = (v >> rot) | (v << (32 - rot));
                        r.carry = v[rot - 1];
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_out_item predict_exec(t_in_item beat);
        t_out_item   res_beat;
        t_alu_op     op;
        t_shift_kind kind;
        t_shift_out  sh;
        logic [31:0] instr, rn, rm, imm32, res, a, b;
        logic [32:0] sum;
        logic        cin, cflag, passed, is_test, set_flags, arith, wr;
        int          rot, imm5;
        instr     = beat.instr;
        rn        = beat.rn_value;
        rm        = beat.rm_value;
        cflag     = model_nzcv[FlagC];
        op        = t_alu_op'(instr[24:21]);
        kind      = t_shift_kind'(instr[6:5]);
        passed    = cond_holds(t_cond'(instr[31:28]), model_nzcv);
        is_test   = op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
        set_flags = is_test || instr[20];

        if (instr[25]) begin
            rot   = 2 * int'(instr[11:8]);
            imm32 = {24'h0, instr[7:0]};
            if (rot == 0) begin
                sh.op2   = imm32;
                sh.carry = cflag;
            end else begin
                sh.op2   = (imm32 >> rot) | (imm32 << (32 - rot));
                sh.carry = sh.op2[31];
            end
        end else if (instr[4]) begin
            sh = shift_operand(rm, int'(beat.rs_value), kind, cflag);
        end else begin
            imm5 = int'(instr[11:7]);
            if (imm5 != 0) begin
                sh = shift_operand(rm, imm5, kind, cflag);
            end else if (kind == SHIFT_LSL) begin
                sh.op2   = rm;
                sh.carry = cflag;
            end else if (kind == SHIFT_ROR) begin
                // RRX: the carry flag enters at the top.
                sh.op2   = {cflag, rm[31:1]};
                sh.carry = rm[0];
            end else begin
                sh = shift_operand(rm, 32, kind, cflag);
            end
        end

        arith = 1'b1;
        a     = rn;
        b     = sh.op2;
        cin   = 1'b0;
        res   = '0;
        case (op)
            OP_AND, OP_TST: begin arith = 1'b0; res = rn & sh.op2; end
            OP_EOR, OP_TEQ: begin arith = 1'b0; res = rn ^ sh.op2; end
            OP_SUB, OP_CMP: begin b = ~sh.op2; cin = 1'b1; end
            OP_RSB:         begin a = sh.op2; b = ~rn; cin = 1'b1; end
            OP_ADD, OP_CMN: begin cin = 1'b0; end
            OP_ADC:         begin cin = cflag; end
            OP_SBC:         begin b = ~sh.op2; cin = cflag; end
            OP_RSC:         begin a = sh.op2; b = ~rn; cin = cflag; end
            OP_ORR:         begin arith = 1'b0; res = rn | sh.op2; end
            OP_MOV:         begin arith = 1'b0; res = sh.op2; end
            OP_BIC:         begin arith = 1'b0; res = rn & ~sh.op2; end
            default:        begin arith = 1'b0; res = ~sh.op2; end
        endcase

        sum = {1'b0, a} + {1'b0, b} + {32'h0, cin};
        if (arith) res = sum[31:0];

        if (passed && set_flags) begin
            model_nzcv[FlagN] = res[31];
            model_nzcv[FlagZ] = (res == '0);
            if (arith) begin
                model_nzcv[FlagC] = sum[32];
                model_nzcv[FlagV] = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
            end else begin
                model_nzcv[FlagC] = sh.carry;
            end
        end

        wr                    = passed && !is_test;
        res_beat.result_value = wr ? res : '0;
        res_beat.rd_index     = instr[15:12];
        res_beat.write_rd     = wr;
        res_beat.cond_passed  = passed;
        res_beat.flags_nzcv   = model_nzcv;
        return res_beat;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] dp_word(t_cond cond, logic imm, t_alu_op op, logic s,
                                            logic [3:0] rd, logic [11:0] op2_field);
        return {cond, 2'b00, imm, op, s, 4'h0, rd, op2_field};
    endfunction

    function automatic t_in_item beat_of(logic [31:0] instr, logic [31:0] rn,
                                         logic [31:0] rm, logic [7:0] rs);
        t_in_item beat;
        beat.instr    = instr;
        beat.rn_value = rn;
        beat.rm_value = rm;
        beat.rs_value = rs;
        return beat;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_beat();
        logic [31:0] instr;
        logic [7:0]  rs;
        instr = $urandom;
        // Half the beats always execute so that the flags keep moving.
        if ($urandom_range(99) < 50) instr[31:28] = COND_AL;
        rs = ($urandom_range(1) == 0) ? 8'($urandom_range(40)) : 8'($urandom);
        return beat_of(instr, rand_operand(), rand_operand(), rs);
    endfunction

    task automatic send_instr(input t_in_item beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        exec_results_q.push_back(predict_exec(beat));
    endtask

    task automatic note_mismatch(input string what, input t_out_item exp_b,
                                 input t_out_item act_b);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s exp res=%h rd=%h wr=%b cp=%b nzcv=%b",
                     $time, what, exp_b.result_value, exp_b.rd_index, exp_b.write_rd,
                     exp_b.cond_passed, exp_b.flags_nzcv);
            $display("    got res=%h rd=%h wr=%b cp=%b nzcv=%b",
                     act_b.result_value, act_b.rd_index, act_b.write_rd,
                     act_b.cond_passed, act_b.flags_nzcv);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exec_results_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, o_out_item);
            end else begin
                exp_beat = exec_results_q.pop_front();
                if (exp_beat.result_value !== o_out_item.result_value ||
                    exp_beat.rd_index     !== o_out_item.rd_index     ||
                    exp_beat.write_rd     !== o_out_item.write_rd     ||
                    exp_beat.cond_passed  !== o_out_item.cond_passed  ||
                    exp_beat.flags_nzcv   !== o_out_item.flags_nzcv) begin
                    note_mismatch("wrong beat", exp_beat, o_out_item);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        logic [7:0]  rs_tab [16] = '{8'd0,  8'd32, 8'd32, 8'd64, 8'd33, 8'd255, 8'd33, 8'd0,
                                     8'd1,  8'd31, 8'd31, 8'd31, 8'd255, 8'd32, 8'd0, 8'd96};
        t_shift_kind kind;
        send_idle_pct = 0;
        out_stall_pct = 0;
        // A rotated immediate of zero sets Z.
        send_instr(beat_of(dp_word(COND_AL, 1'b1, OP_MOV, 1'b1, 4'd0, 12'hF00),
                           '1, '1, 8'hFF));
        // The never condition must leave everything untouched.
        send_instr(beat_of(dp_word(COND_NV, 1'b1, OP_MOV, 1'b1, 4'd1, 12'h0FF),
                           '0, '0, 8'h00));
        send_instr(beat_of(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, 4'd2, 12'h001),
                           32'h7FFF_FFFF, '0, 8'h00));
        send_instr(beat_of(dp_word(COND_AL, 1'b1, OP_ADD, 1'b1, 4'd3, 12'h001),
                           32'hFFFF_FFFF, '0, 8'h00));
        // Every operation through a register-specified shift, with bit 7 set.
        for (int i = 0; i < 16; i++) begin
            kind = t_shift_kind'(i % 4);
            send_instr(beat_of(dp_word(COND_AL, 1'b0, t_alu_op'(i), 1'b1, 4'(i),
                                       {4'h3, 1'b1, kind, 1'b1, 4'h2}),
                               (i % 2 == 1) ? 32'hFFFF_FFFF : 32'($urandom),
                               (i % 4 >= 2) ? (32'h8000_0000 | $urandom) : 32'($urandom),
                               rs_tab[i]));
        end
        // Immediate shifts by zero: plain, shift by 32 twice, and RRX.
        for (int k = 0; k < 4; k++) begin
            send_instr(beat_of(dp_word(COND_AL, 1'b0, OP_MOV, 1'b1, 4'd4,
                                       {5'd0, t_shift_kind'(k), 1'b0, 4'h1}),
                               '0, 32'h8000_0001, 8'h00));
        end
        // Opposite conditions: exactly one of the pair fails.
        send_instr(beat_of(dp_word(COND_EQ, 1'b1, OP_ORR, 1'b0, 4'd5, 12'h0AA),
                           32'h1234_5678, '0, 8'h00));
        send_instr(beat_of(dp_word(COND_NE, 1'b1, OP_ORR, 1'b0, 4'd5, 12'h0AA),
                           32'h1234_5678, '0, 8'h00));
        // R15 destination with S set, and bits 27:26 of no meaning here.
        send_instr(beat_of(dp_word(COND_AL, 1'b0, OP_ADD, 1'b1, 4'hF,
                                   {5'd4, SHIFT_LSL, 1'b0, 4'h1}) | 32'h0C00_0000,
                           32'h8000_0000, 32'h0800_0000, 8'h00));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_instr(rand_beat());
        end
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        out_stall_pct = 73;
        for (int i = 0; i < 20; i++) send_instr(rand_beat());
        i_in_valid <= 1'b0;
        while (exec_results_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 20; i++) send_instr(rand_beat());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_traffic(0, 0, 490);
        test_random_traffic(73, 0, 490);
        test_random_traffic(0, 73, 490);
        test_pause_until_drained();
        test_random_traffic(10, 10, 490);

        i_in_valid <= 1'b0;
        while (exec_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && exec_results_q.size() == 0) begin
            $display("arm_data_processing_alu: match");
        end else begin
            $display("arm_data_processing_alu: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("arm_data_processing_alu: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
design/arm_dp_pkg.sv
design/arm_dp_shifter.sv
design/arm_dp_alu.sv
design/arm_data_processing_alu.sv
tb/tb_arm_data_processing_alu.sv
